[hdl/ip_to_mac_hash_table_assert.svh]
// assertion macros for the hash table rtl
`ifndef IP_TO_MAC_HASH_TABLE_ASSERT_SVH
`define IP_TO_MAC_HASH_TABLE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define IPTM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define IPTM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/iptm_pkg.sv]
// types and constants of the ip to mac hash table
package iptm_pkg;

	localparam int IP_W      = 32;
	localparam int MAC_W     = 48;
	localparam int BUCKETS   = 256;
	localparam int BKT_W     = 8;
	localparam int WAYS_DEF  = 4;
	localparam int FUNC_W    = 2;
	localparam int STATUS_W  = 2;

	localparam logic [MAC_W-1:0] BASE_MAC_RST = 48'hCCCC_CCCC_CC00;

	// request codes
	localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd0;
	localparam logic [FUNC_W-1:0] FN_INSERT = 2'd1;
	localparam logic [FUNC_W-1:0] FN_AUTO   = 2'd2;

	// result codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic             en;
		logic [BKT_W-1:0] bucket;
		logic [IP_W-1:0]  ip;
		logic [MAC_W-1:0] mac;
	} slot_wr_t;

endpackage

[hdl/iptm_if.sv]
// request and response channel interfaces

interface iptm_req_if;
	logic                          valid;
	logic                          ready;
	logic [iptm_pkg::FUNC_W-1:0]   func;
	logic [iptm_pkg::IP_W-1:0]     ip;
	logic [iptm_pkg::MAC_W-1:0]    mac;

	modport source (output valid, output func, output ip, output mac, input ready);
	modport sink   (input valid, input func, input ip, input mac, output ready);
endinterface

interface iptm_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [iptm_pkg::STATUS_W-1:0] status;
	logic [iptm_pkg::MAC_W-1:0]    mac_out;

	modport source (output valid, output status, output mac_out, input ready);
	modport sink   (input valid, input status, input mac_out, output ready);
endinterface

[hdl/iptm_slot_ram.sv]
// slot memory: one row of ip and mac pairs per bucket, one way written at a time
module iptm_slot_ram #(
	parameter int WAYS  = iptm_pkg::WAYS_DEF,
	parameter int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
	input  logic                                   clk,
	input  logic                                   rd_en,
	input  logic [iptm_pkg::BKT_W-1:0]             rd_bucket,
	output logic [WAYS-1:0][iptm_pkg::IP_W-1:0]    rd_ip,
	output logic [WAYS-1:0][iptm_pkg::MAC_W-1:0]   rd_mac,
	input  iptm_pkg::slot_wr_t                     wr,
	input  logic [WAY_W-1:0]                       wr_way
);
	import iptm_pkg::*;

	logic [WAYS-1:0][IP_W-1:0]  ip_mem  [BUCKETS];
	logic [WAYS-1:0][MAC_W-1:0] mac_mem [BUCKETS];
	logic [WAYS-1:0][IP_W-1:0]  rd_ip_q;
	logic [WAYS-1:0][MAC_W-1:0] rd_mac_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			ip_mem[wr.bucket][wr_way]  <= wr.ip;
			mac_mem[wr.bucket][wr_way] <= wr.mac;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_ip_q  <= ip_mem[rd_bucket];
			rd_mac_q <= mac_mem[rd_bucket];
		end
	end

	assign rd_ip  = rd_ip_q;
	assign rd_mac = rd_mac_q;

endmodule

[hdl/iptm_fill_ram.sv]
// bucket fill counts: memory plus a valid bit per bucket so reset clears at once
module iptm_fill_ram #(
	parameter int WAYS   = iptm_pkg::WAYS_DEF,
	parameter int FILL_W = $clog2(WAYS + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [iptm_pkg::BKT_W-1:0] rd_bucket,
	output logic [FILL_W-1:0]          rd_fill,
	input  logic                       wr_en,
	input  logic [iptm_pkg::BKT_W-1:0] wr_bucket,
	input  logic [FILL_W-1:0]          wr_fill
);
	import iptm_pkg::*;

	logic [FILL_W-1:0]  fill_mem [BUCKETS];
	logic [BUCKETS-1:0] valid_q;
	logic [FILL_W-1:0]  rd_fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_bucket] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fill_mem[wr_bucket] <= wr_fill;
		end
	end

	// a bucket never written reads as empty
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_fill_q <= valid_q[rd_bucket] ? fill_mem[rd_bucket] : '0;
		end
	end

	assign rd_fill = rd_fill_q;

endmodule

[hdl/ip_to_mac_hash_table.sv]
// ip to mac hash table: top level with request sequencing and result register
// Maps IPv4 addresses to MAC addresses in 256 buckets chosen by ip[7:0], each with WAYS
// slots filled in order. For each request the accepting edge reads the bucket's
// whole slot row and its fill count from the two memories, and in the next cycle all ways
// are compared at once (newest match wins) and an insert writes one slot and the new count
// back. No new word is taken while one is still held for compare and write-back; a word
// may be accepted while the previous result still waits in the output register, and the
// write-back and result then stall until that register is free. Fill counts are cleared by reset
// directly, so the block is usable straight after reset with no clearing pass.
// Auto-insert stores the configured base address plus a 48-bit counter that advances on
// every auto-insert, also when the bucket is full.
`include "ip_to_mac_hash_table_assert.svh"

module ip_to_mac_hash_table #(
	parameter int WAYS = iptm_pkg::WAYS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	iptm_req_if.sink                   req,
	iptm_rsp_if.source                 rsp,
	input  logic                       cfg_we,
	input  logic [iptm_pkg::MAC_W-1:0] cfg_wdata
);
	import iptm_pkg::*;

	localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int FILL_W = $clog2(WAYS + 1);

	logic                      accept;
	logic                      done;
	logic                      busy_s1;
	logic [FUNC_W-1:0]         func_s1;
	logic [IP_W-1:0]           ip_s1;
	logic [MAC_W-1:0]          mac_s1;
	logic [MAC_W-1:0]          base_mac_q;
	logic [MAC_W-1:0]          ctr_q;
	logic                      rsp_valid_q;
	logic [STATUS_W-1:0]       status_q;
	logic [MAC_W-1:0]          mac_out_q;

	logic [WAYS-1:0][IP_W-1:0]  rd_ip;
	logic [WAYS-1:0][MAC_W-1:0] rd_mac;
	logic [FILL_W-1:0]          rd_fill;

	logic                      is_store;
	logic                      is_auto;
	logic                      full;
	logic                      hit;
	logic [MAC_W-1:0]          hit_mac;
	logic [MAC_W-1:0]          store_mac;
	logic [STATUS_W-1:0]       status_d;
	logic [MAC_W-1:0]          mac_out_d;
	logic                      do_write;
	slot_wr_t                  slot_wr;

	assign accept    = req.valid && req.ready;
	assign req.ready = !busy_s1;
	assign done      = busy_s1 && (!rsp_valid_q || rsp.ready);

	iptm_slot_ram #(.WAYS(WAYS), .WAY_W(WAY_W)) u_slot (
		.clk       (clk),
		.rd_en     (accept),
		.rd_bucket (req.ip[BKT_W-1:0]),
		.rd_ip     (rd_ip),
		.rd_mac    (rd_mac),
		.wr        (slot_wr),
		.wr_way    (rd_fill[WAY_W-1:0])
	);

	iptm_fill_ram #(.WAYS(WAYS), .FILL_W(FILL_W)) u_fill (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_bucket (req.ip[BKT_W-1:0]),
		.rd_fill   (rd_fill),
		.wr_en     (do_write),
		.wr_bucket (ip_s1[BKT_W-1:0]),
		.wr_fill   (rd_fill + FILL_W'(1))
	);

	// request word held for the compare and write-back cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (accept) begin
			busy_s1 <= 1'b1;
		end else if (done) begin
			busy_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= req.func;
			ip_s1   <= req.ip;
			mac_s1  <= req.mac;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_mac_q <= BASE_MAC_RST;
		end else if (cfg_we) begin
			base_mac_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= '0;
		end else if (done && is_auto) begin
			ctr_q <= ctr_q + MAC_W'(1);
		end
	end

	// parallel compare over the filled ways, later ways override earlier ones
	always_comb begin
		hit     = 1'b0;
		hit_mac = '0;
		for (int w = 0; w < WAYS; w++) begin
			if ((FILL_W'(w) < rd_fill) && (rd_ip[w] == ip_s1)) begin
				hit     = 1'b1;
				hit_mac = rd_mac[w];
			end
		end
	end

	always_comb begin
		is_auto   = (func_s1 == FN_AUTO);
		is_store  = (func_s1 == FN_INSERT) || is_auto;
		full      = (rd_fill >= FILL_W'(WAYS));
		store_mac = is_auto ? (base_mac_q + ctr_q) : mac_s1;
		if (is_store) begin
			status_d  = full ? ST_FULL : ST_OK;
			mac_out_d = full ? '0 : store_mac;
		end else begin
			status_d  = hit ? ST_OK : ST_NOT_FOUND;
			mac_out_d = hit ? hit_mac : '0;
		end
		do_write       = done && is_store && !full;
		slot_wr.en     = do_write;
		slot_wr.bucket = ip_s1[BKT_W-1:0];
		slot_wr.ip     = ip_s1;
		slot_wr.mac    = store_mac;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			status_q  <= status_d;
			mac_out_q <= mac_out_d;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.status  = status_q;
	assign rsp.mac_out = mac_out_q;

	`IPTM_ASSERT_NOW(a_fill_bound, busy_s1, rd_fill <= FILL_W'(WAYS), "bucket fill above way count")
	`IPTM_ASSERT_NEXT(a_ctr_step, done && is_auto, ctr_q == $past(ctr_q) + MAC_W'(1), "auto counter did not advance")
	`IPTM_ASSERT_NOW(a_err_zero, rsp_valid_q && status_q != ST_OK, mac_out_q == '0, "mac_out not zero on error")
	`IPTM_ASSERT_NEXT(a_result_after, done, rsp_valid_q && !busy_s1, "result lost after completion")

endmodule
